@@ design/crcfd_pkg.sv @@
package crcfd_pkg;

    localparam logic [15:0] HEAD_RESET = 16'hAA55;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_LENGTH = 2'd2;

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_LEN_HI  = 6'b000010,
        PH_LEN_LO  = 6'b000100,
        PH_CRC_HI  = 6'b001000,
        PH_CRC_LO  = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       has_data;
        logic       frame_end;
        logic [1:0] frame_status;
    } t_result;

    // CRC-16/X-25 update, LSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic [7:0]  d;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

@@ design/crc_frame_deframer.sv @@
// Length-prefixed frame deframer with CRC-16/X-25 check.
// Input channel: one received byte per word (i_in_valid, o_in_stall, i_rx_byte).
// The block hunts for the head word, reads a big-endian length (payload + 2)
// and a big-endian CRC, then forwards each payload byte as an output word.
// The last payload word (or a status-only word for an empty frame or a
// length below 2) carries o_frame_end and o_frame_status.
// Output channel: o_out_valid, i_out_stall and the result fields.
// Config channel: i_cfg_valid/o_cfg_ready/i_cfg_data writes the head word;
// always ready, write only while idle.
// Throughput: one byte per cycle unless the output stalls; the input register
// feeds a single pass of phase and 8-bit CRC logic into the output register.
// Reset: hunting with no held byte, head word 0xAA55, output empty.
// Stall: a stalled output word holds; the input stalls only when a pending
// byte would produce a word and the output register cannot take it.
module crc_frame_deframer import crcfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_data,
    output logic        o_frame_end,
    output logic [1:0]  o_frame_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_head_word;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    t_result     result;
    logic        out_free;
    logic        fire;
    logic        in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_word <= HEAD_RESET;
        end else if (i_cfg_valid) begin
            r_head_word <= i_cfg_data;
        end
    end

    assign fire       = r_in_valid && (!result.valid || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    crcfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .i_head_word (r_head_word),
        .o_result    (result)
    );

    crcfd_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (fire && result.valid),
        .i_result       (result),
        .i_stall        (i_out_stall),
        .o_free         (out_free),
        .o_valid        (o_out_valid),
        .o_payload_byte (o_payload_byte),
        .o_has_data     (o_has_data),
        .o_frame_end    (o_frame_end),
        .o_frame_status (o_frame_status)
    );

endmodule

@@ design/crcfd_core.sv @@
module crcfd_core import crcfd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_head_word,
    output t_result     o_result
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_prev_byte, n_prev_byte;
    logic        r_prev_valid, n_prev_valid;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [15:0] r_exp_crc, n_exp_crc;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_left, n_left;

    logic [15:0] length_val;
    logic [15:0] crc_upd;
    logic [15:0] left_dec;
    t_result     res;

    assign length_val = {r_len_hi, i_byte};
    assign crc_upd    = crc_byte(r_crc, i_byte);
    assign left_dec   = r_left - 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_prev_byte  = r_prev_byte;
        n_prev_valid = r_prev_valid;
        n_len_hi     = r_len_hi;
        n_exp_crc    = r_exp_crc;
        n_crc        = r_crc;
        n_left       = r_left;
        res          = '0;
        unique case (r_phase)
            PH_LEN_HI: begin
                n_len_hi = i_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (length_val < 16'd2) begin
                    n_phase            = PH_HUNT;
                    n_prev_valid       = 1'b0;
                    n_prev_byte        = '0;
                    res.valid          = 1'b1;
                    res.frame_end      = 1'b1;
                    res.frame_status   = ST_LENGTH;
                end else begin
                    n_left  = length_val - 16'd2;
                    n_phase = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                n_exp_crc = {i_byte, 8'h00};
                n_phase   = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_exp_crc = {r_exp_crc[15:8], i_byte};
                n_crc     = CRC_INIT;
                if (r_left == 16'd0) begin
                    n_phase          = PH_HUNT;
                    n_prev_valid     = 1'b0;
                    n_prev_byte      = '0;
                    res.valid        = 1'b1;
                    res.frame_end    = 1'b1;
                    // CRC of no bytes is zero
                    res.frame_status = ({r_exp_crc[15:8], i_byte} == 16'h0000) ? ST_OK : ST_CRC;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_crc            = crc_upd;
                n_left           = left_dec;
                res.valid        = 1'b1;
                res.payload_byte = i_byte;
                res.has_data     = 1'b1;
                if (left_dec == 16'd0) begin
                    n_phase          = PH_HUNT;
                    n_prev_valid     = 1'b0;
                    n_prev_byte      = '0;
                    res.frame_end    = 1'b1;
                    res.frame_status = (~crc_upd == r_exp_crc) ? ST_OK : ST_CRC;
                end
            end
            default: begin
                if (r_prev_valid && r_prev_byte == i_head_word[15:8] &&
                    i_byte == i_head_word[7:0]) begin
                    n_phase      = PH_LEN_HI;
                    n_prev_valid = 1'b0;
                    n_prev_byte  = '0;
                end else begin
                    n_phase      = PH_HUNT;
                    n_prev_byte  = i_byte;
                    n_prev_valid = 1'b1;
                end
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_prev_byte  <= '0;
            r_prev_valid <= 1'b0;
            r_len_hi     <= '0;
            r_exp_crc    <= '0;
            r_crc        <= CRC_INIT;
            r_left       <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_prev_byte  <= n_prev_byte;
            r_prev_valid <= n_prev_valid;
            r_len_hi     <= n_len_hi;
            r_exp_crc    <= n_exp_crc;
            r_crc        <= n_crc;
            r_left       <= n_left;
        end
    end

endmodule

@@ design/crcfd_out_reg.sv @@
module crcfd_out_reg import crcfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    input  logic       i_stall,
    output logic       o_free,
    output logic       o_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_has_data,
    output logic       o_frame_end,
    output logic [1:0] o_frame_status
);

    logic       r_valid;
    logic [7:0] r_payload_byte;
    logic       r_has_data;
    logic       r_frame_end;
    logic [1:0] r_frame_status;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_payload_byte <= i_result.payload_byte;
            r_has_data     <= i_result.has_data;
            r_frame_end    <= i_result.frame_end;
            r_frame_status <= i_result.frame_status;
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_payload_byte;
    assign o_has_data     = r_has_data;
    assign o_frame_end    = r_frame_end;
    assign o_frame_status = r_frame_status;

endmodule

@@ verif/tb.sv @@
module tb import crcfd_pkg::*; ();

    class frame_scoreboard;
        logic [15:0] head;
        t_phase      phase;
        logic [7:0]  prev_byte;
        logic        prev_valid;
        logic [15:0] len_field;
        logic [15:0] crc_want;
        logic [15:0] crc_run;
        logic [15:0] left;
        t_result     expected_words[$];
        int          mismatches;

        function new();
            head       = HEAD_RESET;
            phase      = PH_HUNT;
            prev_byte  = 8'h00;
            prev_valid = 1'b0;
            len_field  = 16'h0000;
            crc_want   = 16'h0000;
            crc_run    = CRC_INIT;
            left       = 16'h0000;
            mismatches = 0;
        endfunction

        // reflected X-25 update, data LSB first
        static function logic [15:0] crc_update(logic [15:0] c, logic [7:0] d);
            logic [15:0] r;
            logic        fb;
            int          i;
            r = c;
            for (i = 0; i < 8; i++) begin
                fb = r[0] ^ d[i];
                r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
            end
            return r;
        endfunction

        function void push_word(logic [7:0] b, logic hd, logic fe, logic [1:0] st);
            t_result w;
            w.valid        = 1'b1;
            w.payload_byte = b;
            w.has_data     = hd;
            w.frame_end    = fe;
            w.frame_status = st;
            expected_words.push_back(w);
        endfunction

        function void restart();
            phase      = PH_HUNT;
            prev_valid = 1'b0;
            prev_byte  = 8'h00;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [15:0] fin;
            case (phase)
                PH_LEN_HI: begin
                    len_field = {b, 8'h00};
                    phase     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_field = {len_field[15:8], b};
                    if (len_field < 16'd2) begin
                        restart();
                        push_word(8'h00, 1'b0, 1'b1, ST_LENGTH);
                    end else begin
                        left  = len_field - 16'd2;
                        phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    crc_want = {b, 8'h00};
                    phase    = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    crc_want = {crc_want[15:8], b};
                    crc_run  = CRC_INIT;
                    if (left == 16'd0) begin
                        fin = ~crc_run;
                        restart();
                        push_word(8'h00, 1'b0, 1'b1, (fin == crc_want) ? ST_OK : ST_CRC);
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    crc_run = crc_update(crc_run, b);
                    left    = left - 16'd1;
                    if (left == 16'd0) begin
                        fin = ~crc_run;
                        restart();
                        push_word(b, 1'b1, 1'b1, (fin == crc_want) ? ST_OK : ST_CRC);
                    end else begin
                        push_word(b, 1'b1, 1'b0, ST_OK);
                    end
                end
                default: begin
                    if (prev_valid && prev_byte == head[15:8] && b == head[7:0]) begin
                        phase      = PH_LEN_HI;
                        prev_valid = 1'b0;
                        prev_byte  = 8'h00;
                    end else begin
                        phase      = PH_HUNT;
                        prev_byte  = b;
                        prev_valid = 1'b1;
                    end
                end
            endcase
        endfunction

        function void check_word(logic [7:0] b, logic hd, logic fe, logic [1:0] st);
            t_result w;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: byte %02h data %0b end %0b status %0d",
                             b, hd, fe, st);
                end
                return;
            end
            w = expected_words.pop_front();
            if (w.payload_byte !== b || w.has_data !== hd || w.frame_end !== fe ||
                w.frame_status !== st) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"word mismatch: want byte %02h data %0b end %0b status %0d,",
                              " got byte %02h data %0b end %0b status %0d"},
                             w.payload_byte, w.has_data, w.frame_end, w.frame_status,
                             b, hd, fe, st);
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte      = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_has_data;
    logic        o_frame_end;
    logic [1:0]  o_frame_status;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data     = 16'h0000;

    frame_scoreboard sb;
    logic [15:0]     cur_head    = HEAD_RESET;
    bit              quiet       = 1'b0;
    int              hold_cycles = 0;
    int              sent_bytes  = 0;

    crc_frame_deframer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_payload_byte (o_payload_byte),
        .o_has_data     (o_has_data),
        .o_frame_end    (o_frame_end),
        .o_frame_status (o_frame_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.check_word(o_payload_byte, o_has_data, o_frame_end, o_frame_status);
            end
            if (i_in_valid && !o_in_stall) begin
                sb.note_byte(i_rx_byte);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.head = i_cfg_data;
            end
        end
    end

    // receiver: random stall bursts, plus long hold-offs on request
    initial begin
        repeat (6) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sent_bytes++;
    endtask

    task automatic send_list(input logic [7:0] q[$]);
        int i;
        for (i = 0; i < q.size(); i++) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            send_byte(q[i]);
        end
    endtask

    task automatic wait_drained(input int settle);
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_head(input logic [15:0] w);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_head = w;
    endtask

    // keep < full size cuts the frame short
    task automatic send_frame(input int plen, input bit corrupt, input int keep);
        logic [7:0]  q[$];
        logic [7:0]  p[$];
        logic [15:0] crc;
        logic [15:0] len;
        logic [7:0]  d;
        int          i;
        crc = CRC_INIT;
        len = 16'(plen + 2);
        for (i = 0; i < plen; i++) begin
            d = 8'($urandom_range(0, 255));
            crc = frame_scoreboard::crc_update(crc, d);
            p.push_back(d);
        end
        crc = ~crc;
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        end
        q.push_back(cur_head[15:8]);
        q.push_back(cur_head[7:0]);
        q.push_back(len[15:8]);
        q.push_back(len[7:0]);
        q.push_back(crc[15:8]);
        q.push_back(crc[7:0]);
        for (i = 0; i < plen; i++) begin
            q.push_back(p[i]);
        end
        while (q.size() > keep) begin
            void'(q.pop_back());
        end
        send_list(q);
    endtask

    task automatic random_traffic(input int n);
        logic [7:0] q[$];
        int         stop;
        int         k;
        int         plen;
        int         i;
        stop = sent_bytes + n;
        while (sent_bytes < stop) begin
            k = $urandom_range(0, 99);
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
            q.delete();
            if (k < 65) begin
                send_frame(plen, 1'b0, 1 << 30);
            end else if (k < 75) begin
                send_frame(plen, 1'b1, 1 << 30);
            end else if (k < 80) begin
                q.push_back(cur_head[15:8]);
                q.push_back(cur_head[7:0]);
                q.push_back(8'h00);
                q.push_back(8'($urandom_range(0, 1)));
                send_list(q);
            end else if (k < 85) begin
                send_frame(0, 1'($urandom_range(0, 1)), 1 << 30);
            end else if (k < 95) begin
                for (i = 0; i < $urandom_range(1, 8); i++) begin
                    q.push_back(($urandom_range(0, 3) == 0) ? cur_head[15:8]
                                                            : 8'($urandom_range(0, 255)));
                end
                send_list(q);
            end else begin
                plen = $urandom_range(1, 20);
                send_frame(plen, 1'b0, $urandom_range(1, plen + 5));
            end
        end
    endtask

    initial begin
        logic [7:0]  dq[$];
        logic [15:0] c1;
        logic [15:0] c2;
        sb = new();
        c1 = ~frame_scoreboard::crc_update(CRC_INIT, 8'hFF);
        c2 = ~frame_scoreboard::crc_update(CRC_INIT, 8'h00);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // overlapping head, one-byte frame, short length, empty ok, empty bad
        dq = '{8'hAA, 8'hAA, 8'h55, 8'h00, 8'h03, c1[15:8], c1[7:0], 8'hFF,
               8'hAA, 8'h55, 8'h00, 8'h01,
               8'hAA, 8'h55, 8'h00, 8'h02, 8'h00, 8'h00,
               8'hAA, 8'h55, 8'h00, 8'h02, 8'h12, 8'h34};
        send_list(dq);

        // head word rewritten in the middle of a frame
        dq = '{cur_head[15:8], cur_head[7:0], 8'h00};
        send_list(dq);
        wait_drained(4);
        write_head(16'h0000);
        dq = '{8'h03, c2[15:8], c2[7:0], 8'h00};
        send_list(dq);

        random_traffic(200);
        wait_drained(4);
        write_head(16'hFFFF);
        random_traffic(200);
        wait_drained(4);
        write_head(16'hAAAA);
        random_traffic(150);
        wait_drained(4);
        write_head(16'($urandom_range(0, 65535)));
        random_traffic(200);

        send_frame(300, 1'b0, 1 << 30);
        send_frame(300, 1'b1, 1 << 30);

        // long receiver hold while the sender keeps pushing
        wait_drained(4);
        hold_cycles = 150;
        quiet = 1'b1;
        send_frame(60, 1'b0, 1 << 30);
        quiet = 1'b0;
        wait_drained(4);

        write_head(HEAD_RESET);
        random_traffic(150);
        quiet = 1'b1;
        random_traffic(200);

        wait_drained(20);
        if (sb.pending() != 0) begin
            sb.mismatches += sb.pending();
        end
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
